### src/bis_pkg.sv
// shared types, constants and the opcode table of the bytecode instruction splitter
// no dependencies; used by bis_parser, bis_out_reg and bytecode_instruction_splitter
package bis_pkg;

    localparam int ADDR_BYTES = 8;
    localparam int TABLE_SIZE = 31;

    localparam logic [2:0] FBC_ADDR_LAST = 3'(ADDR_BYTES - 1);
    localparam logic [2:0] FBC_VAL_LAST  = 3'd7;
    localparam logic [7:0] OPCODE_LIMIT  = 8'(TABLE_SIZE);

    localparam logic [1:0] AK_NONE = 2'd0;
    localparam logic [1:0] AK_ADDR = 2'd1;
    localparam logic [1:0] AK_VAL  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_OP    = 2'd1;
    localparam logic [1:0] ST_BIG_COUNT = 2'd2;

    typedef enum logic [1:0] {
        TK_NONE,
        TK_ADDR,
        TK_VAL,
        TK_VAR
    } t_tab_kind;

    typedef struct packed {
        logic [31:0] instr_offset;
        logic [7:0]  opcode;
        logic [1:0]  arg_kind;
        logic [16:0] arg_index;
        logic [63:0] arg_bits;
        logic        last_of_instr;
        logic [1:0]  status;
    } t_result;

    function automatic t_tab_kind op_kind(input logic [4:0] op);
        t_tab_kind k;
        unique case (op) inside
            5'd0:                                    k = TK_VAR;
            5'd4:                                    k = TK_VAL;
            5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd8, 5'd9,
            5'd25, 5'd26, 5'd27, 5'd29, 5'd30:       k = TK_ADDR;
            default:                                 k = TK_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] op_count(input logic [4:0] op);
        logic [1:0] c;
        unique case (op) inside
            5'd2, 5'd3:                              c = 2'd2;
            5'd0, 5'd1, 5'd4, 5'd5, 5'd6, 5'd8, 5'd9,
            5'd25, 5'd26, 5'd27, 5'd29, 5'd30:       c = 2'd1;
            default:                                 c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

### src/bis_parser.sv
// parse state and per-byte decode: one byte in, at most one result out
// depends on bis_pkg
module bis_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output logic             o_res_vld,
    output bis_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_FIXED,
        PH_VADDR,
        PH_VCOUNT,
        PH_VVALS
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_byte_offset, n_byte_offset;
    logic [31:0] r_start, n_start;
    logic [7:0]  r_opcode, n_opcode;
    logic [2:0]  r_fbc, n_fbc;
    logic [63:0] r_asm, n_asm;
    logic [16:0] r_arg_cnt, n_arg_cnt;
    logic [15:0] r_vleft, n_vleft;

    bis_pkg::t_tab_kind cur_kind, new_kind;
    logic [1:0]         cur_count;
    logic               is_val;
    logic               field_done;
    logic [63:0]        word;
    logic [15:0]        vl_dec;
    logic               last;

    always_comb begin
        cur_kind   = bis_pkg::op_kind(r_opcode[4:0]);
        cur_count  = bis_pkg::op_count(r_opcode[4:0]);
        new_kind   = bis_pkg::op_kind(i_byte[4:0]);
        is_val     = (r_phase == PH_VVALS)
                     || (r_phase == PH_FIXED && cur_kind == bis_pkg::TK_VAL);
        field_done = is_val ? (r_fbc == bis_pkg::FBC_VAL_LAST)
                            : (r_fbc == bis_pkg::FBC_ADDR_LAST);
        word       = r_asm | (64'(i_byte) << {r_fbc, 3'b000});
        vl_dec     = (r_vleft != 16'd0) ? r_vleft - 16'd1 : 16'd0;
        last       = 1'b0;

        n_phase       = r_phase;
        n_byte_offset = r_byte_offset + 32'd1;
        n_start       = r_start;
        n_opcode      = r_opcode;
        n_fbc         = r_fbc;
        n_asm         = r_asm;
        n_arg_cnt     = r_arg_cnt;
        n_vleft       = r_vleft;

        o_res_vld           = 1'b0;
        o_res.instr_offset  = r_start;
        o_res.opcode        = r_opcode;
        o_res.arg_kind      = bis_pkg::AK_NONE;
        o_res.arg_index     = r_arg_cnt;
        o_res.arg_bits      = word;
        o_res.last_of_instr = 1'b0;
        o_res.status        = bis_pkg::ST_OK;

        if (r_phase == PH_OPCODE) begin
            n_start   = r_byte_offset;
            n_opcode  = i_byte;
            n_fbc     = 3'd0;
            n_asm     = 64'd0;
            n_arg_cnt = 17'd0;
            n_vleft   = 16'd0;
            o_res.instr_offset  = r_byte_offset;
            o_res.opcode        = i_byte;
            o_res.arg_index     = 17'd0;
            o_res.arg_bits      = 64'd0;
            o_res.last_of_instr = 1'b1;
            if (i_byte >= bis_pkg::OPCODE_LIMIT) begin
                o_res_vld    = 1'b1;
                o_res.status = bis_pkg::ST_BAD_OP;
            end else if (new_kind == bis_pkg::TK_NONE) begin
                o_res_vld = 1'b1;
            end else begin
                n_phase = (new_kind == bis_pkg::TK_VAR) ? PH_VADDR : PH_FIXED;
            end
        end else if (!field_done) begin
            n_asm = word;
            n_fbc = r_fbc + 3'd1;
        end else begin
            n_asm     = 64'd0;
            n_fbc     = 3'd0;
            o_res_vld = 1'b1;
            unique case (r_phase)
                PH_FIXED: begin
                    last = (r_arg_cnt + 17'd1) >= 17'(cur_count);
                    o_res.arg_kind = (cur_kind == bis_pkg::TK_VAL) ? bis_pkg::AK_VAL
                                                                    : bis_pkg::AK_ADDR;
                    o_res.last_of_instr = last;
                    if (last) begin
                        n_phase   = PH_OPCODE;
                        n_arg_cnt = 17'd0;
                    end else begin
                        n_arg_cnt = r_arg_cnt + 17'd1;
                    end
                end
                PH_VADDR: begin
                    o_res.arg_kind = bis_pkg::AK_ADDR;
                    n_arg_cnt      = 17'd1;
                    n_phase        = PH_VCOUNT;
                end
                PH_VCOUNT: begin
                    o_res.arg_kind = bis_pkg::AK_ADDR;
                    if (word[63:16] != 48'd0) begin
                        o_res.last_of_instr = 1'b1;
                        o_res.status        = bis_pkg::ST_BIG_COUNT;
                        n_phase             = PH_OPCODE;
                        n_arg_cnt           = 17'd0;
                    end else if (word[15:0] == 16'd0) begin
                        o_res.last_of_instr = 1'b1;
                        n_phase             = PH_OPCODE;
                        n_arg_cnt           = 17'd0;
                    end else begin
                        n_vleft   = word[15:0];
                        n_arg_cnt = 17'd2;
                        n_phase   = PH_VVALS;
                    end
                end
                PH_VVALS: begin
                    last                = (vl_dec == 16'd0);
                    n_vleft             = vl_dec;
                    o_res.arg_kind      = bis_pkg::AK_VAL;
                    o_res.last_of_instr = last;
                    if (last) begin
                        n_phase   = PH_OPCODE;
                        n_arg_cnt = 17'd0;
                    end else begin
                        n_arg_cnt = r_arg_cnt + 17'd1;
                    end
                end
                default: begin
                    n_phase = PH_OPCODE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_OPCODE;
            r_byte_offset <= 32'd0;
            r_start       <= 32'd0;
            r_opcode      <= 8'd0;
            r_fbc         <= 3'd0;
            r_asm         <= 64'd0;
            r_arg_cnt     <= 17'd0;
            r_vleft       <= 16'd0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_byte_offset <= n_byte_offset;
            r_start       <= n_start;
            r_opcode      <= n_opcode;
            r_fbc         <= n_fbc;
            r_asm         <= n_asm;
            r_arg_cnt     <= n_arg_cnt;
            r_vleft       <= n_vleft;
        end
    end

    // value phase always has at least one value pending
    a_vleft_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_VVALS |-> r_vleft != 16'd0)
        else $error("value phase with no values left");

    // an instruction end returns the parser to the opcode byte
    a_last_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res_vld && o_res.last_of_instr |=> r_phase == PH_OPCODE)
        else $error("parser not resynced after instruction end");

    // an error result always closes the instruction
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld && o_res.status != bis_pkg::ST_OK |-> o_res.last_of_instr)
        else $error("error result without last mark");

    // every consumed byte advances the stream offset by one
    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> r_byte_offset == $past(r_byte_offset) + 32'd1)
        else $error("byte offset did not advance");

endmodule

### src/bis_out_reg.sv
// result register: holds one result until the downstream side takes it
// depends on bis_pkg
module bis_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bis_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output bis_pkg::t_result o_res
);

    logic             r_vld;
    bis_pkg::t_result r_res;

    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### src/bytecode_instruction_splitter.sv
// top level of the bytecode instruction splitter: input register, parser, result register
// depends on bis_pkg, bis_parser and bis_out_reg
//
//   channel   handshake                  payload
//   in        i_in_valid / o_in_ready    i_code_byte
//   out       o_out_valid / i_out_ready  o_instr_offset o_opcode o_arg_kind o_arg_index
//                                        o_arg_bits o_last_of_instr o_status
//
// one byte per cycle unless the output stalls; bytes are parsed from the input register
// a result is loaded into the result register when its last byte is parsed
// reset clears the parse state, offsets and the valid flags of both register stages
// a stalled output holds its result; the parser and input stage then hold too
module bytecode_instruction_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_code_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_instr_offset,
    output logic [7:0]  o_opcode,
    output logic [1:0]  o_arg_kind,
    output logic [16:0] o_arg_index,
    output logic [63:0] o_arg_bits,
    output logic        o_last_of_instr,
    output logic [1:0]  o_status
);

    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             out_free;
    logic             fire;
    logic             res_vld;
    bis_pkg::t_result res;
    bis_pkg::t_result out_res;

    assign fire       = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_code_byte;
        end
    end

    bis_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_in_byte),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    bis_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && res_vld),
        .i_res   (res),
        .i_ready (i_out_ready),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_instr_offset  = out_res.instr_offset;
    assign o_opcode        = out_res.opcode;
    assign o_arg_kind      = out_res.arg_kind;
    assign o_arg_index     = out_res.arg_index;
    assign o_arg_bits      = out_res.arg_bits;
    assign o_last_of_instr = out_res.last_of_instr;
    assign o_status        = out_res.status;

endmodule
